// ===== rtl/hid_descriptor_usage_finder_top_assert.svh =====
// Assertion macros used by the checker file of the descriptor usage finder.
// Each macro expands to one labeled concurrent assertion on clk.
`ifndef HID_DESCRIPTOR_USAGE_FINDER_TOP_ASSERT_SVH
`define HID_DESCRIPTOR_USAGE_FINDER_TOP_ASSERT_SVH

// Check a property while out of reset.
`define HDUF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset cycles included.
`define HDUF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hduf_pkg.sv =====
// ----------------------------------------------------------------------------
// hduf_pkg
// Shared types and constants of the HID descriptor usage finder: word
// structs of both channels, fault codes and stack sizing.
// ----------------------------------------------------------------------------
package hduf_pkg;

  // Global stack sizing
  localparam int STACK_DEPTH = 8;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int STK_IW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Fixed codes of the descriptor format
  localparam logic [7:0]  LONG_PREFIX   = 8'hfe;
  localparam logic [31:0] KEYBOARD_PAGE = 32'd7;
  localparam logic [31:0] TARGET_RESET  = 32'h0000_0073;

  // Parse fault codes, first fault wins
  typedef enum logic [2:0] {
    FAULT_NONE  = 3'd0,
    FAULT_LONG  = 3'd1,
    FAULT_TRUNC = 3'd2,
    FAULT_OVER  = 3'd3,
    FAULT_UNDER = 3'd4
  } fault_t;

  // Input word: one descriptor byte with its last mark
  typedef struct packed {
    logic [7:0] desc_byte;
    logic       desc_last;
  } in_word_t;

  // Result word: one per descriptor
  typedef struct packed {
    logic   usage_supported;
    fault_t fault_code;
  } out_word_t;

endpackage

// ===== rtl/hid_descriptor_usage_finder_top.sv =====
// ----------------------------------------------------------------------------
// hid_descriptor_usage_finder_top
// Parses a HID report descriptor byte by byte and reports, on the last byte,
// whether the target keyboard usage is declared in an Input array item.
// ----------------------------------------------------------------------------
//  channel   | ports                              | moves
//  ----------+------------------------------------+-----------------------------
//  input     | in_valid, in_stall, in_data        | one descriptor byte per word
//  result    | out_valid, out_stall, out_data     | one word per last byte
//  config    | psel, penable, pwrite, paddr, ...  | target_usage at address 0
//
// One word is taken every cycle while in_stall is low. A word passes the input
// register, is decoded in a single step against the parse state, and the result
// for a last byte is loaded into the result register when that byte is decoded.
// in_stall rises only when a last byte waits behind a stalled result word.
// rst_n (synchronous) clears the parse state and sets target_usage to 0x73;
// the global stack contents are not cleared.
module hid_descriptor_usage_finder_top (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  hduf_pkg::in_word_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output hduf_pkg::out_word_t out_data,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Item types and tags
  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;
  localparam logic [3:0] TAG_PAGE    = 4'd0;
  localparam logic [3:0] TAG_LMIN    = 4'd1;
  localparam logic [3:0] TAG_LMAX    = 4'd2;
  localparam logic [3:0] TAG_PUSH    = 4'd10;
  localparam logic [3:0] TAG_POP     = 4'd11;
  localparam logic [3:0] TAG_UMIN    = 4'd1;
  localparam logic [3:0] TAG_UMAX    = 4'd2;
  localparam logic [3:0] TAG_INPUT   = 4'd8;
  localparam logic       REG_TARGET  = 1'b0;

  typedef struct packed {
    logic [31:0] page;
    logic [31:0] minimum;
    logic [31:0] maximum;
  } glob_t;

  // Configuration
  logic [31:0] target_r;
  logic        cfg_we;

  // Input register
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       proc;
  logic       in_accept;

  // Parse state
  logic [2:0]              pending_r, pending_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic [1:0]              type_r, type_nxt;
  logic [3:0]              tag_r, tag_nxt;
  logic [31:0]             value_r, value_nxt;
  logic [31:0]             page_r, page_nxt;
  logic [31:0]             lmin_r, lmin_nxt;
  logic [31:0]             lmax_r, lmax_nxt;
  logic [hduf_pkg::LVL_W-1:0] level_r, level_nxt;
  logic [31:0]             umin_r, umin_nxt;
  logic [31:0]             umax_r, umax_nxt;
  logic                    found_r, found_nxt;
  hduf_pkg::fault_t        fault_r, fault_nxt;

  // Stack, with the newest entry kept in a register
  glob_t                       stack_mem [hduf_pkg::STACK_DEPTH];
  glob_t                       top_r;
  logic                        push_we;
  logic                        pop_re;
  logic [hduf_pkg::STK_IW-1:0] push_idx;
  logic [hduf_pkg::STK_IW-1:0] below_idx;
  logic [hduf_pkg::LVL_W-1:0]  level_dec;
  logic [hduf_pkg::LVL_W-1:0]  level_dec2;

  // Item execution
  logic        run_go;
  logic [1:0]  run_type;
  logic [3:0]  run_tag;
  logic [31:0] run_v;
  logic [1:0]  size_code;

  // Result
  logic                out_valid_r, out_valid_nxt;
  hduf_pkg::out_word_t out_data_r;
  logic                out_load;
  hduf_pkg::fault_t    fin_fault;
  logic                fin_supported;

  // Register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_TARGET);
  assign prdata = (paddr[2] == REG_TARGET) ? target_r : 32'd0;

  // Handshake: a byte moves on unless it is a last byte facing a full stalled output
  assign proc      = s1_v_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_v_r && !proc;
  assign in_accept = in_valid && !in_stall;

  // Stack addressing: push slot, and the entry under the top for a pop
  assign push_idx   = level_r[hduf_pkg::STK_IW-1:0];
  assign level_dec  = level_r - 1'b1;
  assign level_dec2 = level_r - 2'd2;
  assign below_idx  = level_dec2[hduf_pkg::STK_IW-1:0];
  assign size_code  = s1_byte_r[1:0];

  // Decode one byte, run a completed item, close the descriptor on the last byte
  always_comb begin
    pending_nxt   = pending_r;
    idx_nxt       = idx_r;
    type_nxt      = type_r;
    tag_nxt       = tag_r;
    value_nxt     = value_r;
    page_nxt      = page_r;
    lmin_nxt      = lmin_r;
    lmax_nxt      = lmax_r;
    level_nxt     = level_r;
    umin_nxt      = umin_r;
    umax_nxt      = umax_r;
    found_nxt     = found_r;
    fault_nxt     = fault_r;
    push_we       = 1'b0;
    pop_re        = 1'b0;
    run_go        = 1'b0;
    run_type      = s1_byte_r[3:2];
    run_tag       = s1_byte_r[7:4];
    run_v         = 32'd0;
    out_load      = 1'b0;
    fin_fault     = hduf_pkg::FAULT_NONE;
    fin_supported = 1'b0;

    // byte decode, skipped once a fault is latched
    if (proc && (fault_r == hduf_pkg::FAULT_NONE)) begin
      if (pending_r == 3'd0) begin
        if (s1_byte_r == hduf_pkg::LONG_PREFIX) begin
          fault_nxt = hduf_pkg::FAULT_LONG;
        end else begin
          type_nxt    = s1_byte_r[3:2];
          tag_nxt     = s1_byte_r[7:4];
          value_nxt   = 32'd0;
          idx_nxt     = 2'd0;
          pending_nxt = (size_code == 2'd3) ? 3'd4 : {1'b0, size_code};
          run_go      = (size_code == 2'd0);
        end
      end else begin
        value_nxt   = value_r | (32'(s1_byte_r) << {idx_r, 3'b000});
        idx_nxt     = idx_r + 2'd1;
        pending_nxt = pending_r - 3'd1;
        run_go      = (pending_r == 3'd1);
        run_type    = type_r;
        run_tag     = tag_r;
        run_v       = value_nxt;
      end
    end

    // execute a complete item
    if (run_go) begin
      case (run_type)
        TYPE_GLOBAL: begin
          case (run_tag)
            TAG_PAGE: page_nxt = run_v;
            TAG_LMIN: lmin_nxt = run_v;
            TAG_LMAX: lmax_nxt = run_v;
            TAG_PUSH: begin
              if (level_r >= hduf_pkg::LVL_W'(hduf_pkg::STACK_DEPTH)) begin
                fault_nxt = hduf_pkg::FAULT_OVER;
              end else begin
                push_we   = 1'b1;
                level_nxt = level_r + 1'b1;
              end
            end
            TAG_POP: begin
              if (level_r == '0) begin
                fault_nxt = hduf_pkg::FAULT_UNDER;
              end else begin
                pop_re    = 1'b1;
                level_nxt = level_dec;
                page_nxt  = top_r.page;
                lmin_nxt  = top_r.minimum;
                lmax_nxt  = top_r.maximum;
              end
            end
            default: ;
          endcase
        end
        TYPE_LOCAL: begin
          if (run_tag == TAG_UMIN) umin_nxt = run_v;
          if (run_tag == TAG_UMAX) umax_nxt = run_v;
        end
        TYPE_MAIN: begin
          if ((run_tag == TAG_INPUT) && (run_v[1:0] == 2'b00) &&
              (page_r == hduf_pkg::KEYBOARD_PAGE) && (lmin_r == 32'd0) &&
              (lmax_r >= target_r) && (umin_r <= target_r) && (umax_r >= target_r)) begin
            found_nxt = 1'b1;
          end
          umin_nxt = '1;
          umax_nxt = 32'd0;
        end
        default: ;
      endcase
    end

    // close the descriptor: form the result and return to reset values
    if (proc && s1_last_r) begin
      out_load  = 1'b1;
      fin_fault = ((fault_nxt == hduf_pkg::FAULT_NONE) && (pending_nxt != 3'd0)) ?
                  hduf_pkg::FAULT_TRUNC : fault_nxt;
      fin_supported = (fin_fault == hduf_pkg::FAULT_NONE) && found_nxt && (level_nxt == '0);
      pending_nxt = 3'd0;
      idx_nxt     = 2'd0;
      type_nxt    = 2'd0;
      tag_nxt     = 4'd0;
      value_nxt   = 32'd0;
      page_nxt    = 32'd0;
      lmin_nxt    = 32'd0;
      lmax_nxt    = 32'd0;
      level_nxt   = '0;
      umin_nxt    = '1;
      umax_nxt    = 32'd0;
      found_nxt   = 1'b0;
      fault_nxt   = hduf_pkg::FAULT_NONE;
    end
  end

  // Hold a result until taken
  assign out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  // Control and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= hduf_pkg::TARGET_RESET;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pending_r   <= 3'd0;
      idx_r       <= 2'd0;
      type_r      <= 2'd0;
      tag_r       <= 4'd0;
      value_r     <= 32'd0;
      page_r      <= 32'd0;
      lmin_r      <= 32'd0;
      lmax_r      <= 32'd0;
      level_r     <= '0;
      umin_r      <= '1;
      umax_r      <= 32'd0;
      found_r     <= 1'b0;
      fault_r     <= hduf_pkg::FAULT_NONE;
    end else begin
      if (cfg_we) begin
        target_r <= pwdata;
      end
      s1_v_r      <= in_accept ? 1'b1 : (proc ? 1'b0 : s1_v_r);
      out_valid_r <= out_valid_nxt;
      pending_r   <= pending_nxt;
      idx_r       <= idx_nxt;
      type_r      <= type_nxt;
      tag_r       <= tag_nxt;
      value_r     <= value_nxt;
      page_r      <= page_nxt;
      lmin_r      <= lmin_nxt;
      lmax_r      <= lmax_nxt;
      level_r     <= level_nxt;
      umin_r      <= umin_nxt;
      umax_r      <= umax_nxt;
      found_r     <= found_nxt;
      fault_r     <= fault_nxt;
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_data.desc_byte;
      s1_last_r <= in_data.desc_last;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.usage_supported <= fin_supported;
      out_data_r.fault_code      <= fin_fault;
    end
  end

  // Save the global set on push; refill the top entry from below on pop
  always_ff @(posedge clk) begin
    if (push_we) begin
      stack_mem[push_idx] <= '{page: page_r, minimum: lmin_r, maximum: lmax_r};
      top_r               <= '{page: page_r, minimum: lmin_r, maximum: lmax_r};
    end else if (pop_re) begin
      top_r <= stack_mem[below_idx];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/hduf_checker.sv =====
// ----------------------------------------------------------------------------
// hduf_checker
// Port-level checks of the descriptor usage finder, bound to its top level.
// ----------------------------------------------------------------------------
`include "hid_descriptor_usage_finder_top_assert.svh"

module hduf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input hduf_pkg::out_word_t out_data,
  input logic                pready
);

  // a stalled result word holds
  `HDUF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "word moved")

  // a supported answer never carries a fault
  `HDUF_ASSERT(a_ok_no_fault, out_valid |-> !(out_data.usage_supported && |out_data.fault_code), "ok with fault")

  // fault codes stay within the defined set
  `HDUF_ASSERT(a_fault_range, out_valid |-> out_data.fault_code <= hduf_pkg::FAULT_UNDER, "bad fault code")

  // no result right after reset, and the register port does not wait then
  `HDUF_ASSERT_ALWAYS(a_reset_quiet, $past(!rst_n) |-> !out_valid && pready, "busy after reset")

endmodule

bind hid_descriptor_usage_finder_top hduf_checker u_hduf_checker (.*);
